/* sv/mnva_pkg.sv */
// Shared constants and controller/datapath interface types for the MIDI voice allocator.
`default_nettype none
package mnva_pkg;

  localparam int VOICES_PER_CHIP = 6;
  localparam int CHIP_COUNT      = 3;
  localparam int VOICE_TOTAL     = VOICES_PER_CHIP * CHIP_COUNT;

  localparam int VIDX_W = (VOICE_TOTAL > 1) ? $clog2(VOICE_TOTAL) : 1;
  localparam int CHIP_W = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;
  localparam int SLOT_W = (VOICES_PER_CHIP > 1) ? $clog2(VOICES_PER_CHIP) : 1;

  localparam int          DRUM_W     = 4;
  localparam logic [3:0]  DRUM_RESET = 4'd9;

  // controller -> datapath
  typedef struct packed {
    logic scan_clear;
    logic scan_adv;
    logic take_hit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic note_ready;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* sv/midi_note_voice_allocator.sv */
// Top level of the MIDI note voice allocator: config register, controller and datapath.
// Takes one raw MIDI byte per rx transaction and hands notes to CHIP_COUNT chips of
// VOICES_PER_CHIP voices. Status bytes with high nibble 8, 9, B take two data bytes,
// C takes one, anything else is dropped alone. A completed note-on (channel not equal
// to drum_channel) claims the first free voice, chip then slot, and posts a key-on
// event; a note-off frees the first busy voice holding that note and posts key-off.
// Rate: a byte that does not finish a note message is taken without a stall, and the
// next byte can follow in the next cycle. A byte that finishes a note message starts
// a scan of the voice table, one voice per cycle; the block takes no byte until the
// scan ends, which is at the matching voice or, when no voice matches, after the last
// of the VOICE_TOTAL voices. A found voice also waits while the previous event still
// sits stalled in the output register. A byte can be taken while an event waits at
// the output.
`default_nettype none
module midi_note_voice_allocator
  import mnva_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // byte input
  input  wire logic        rx_valid,
  output logic             rx_stall,
  input  wire logic [7:0]  rx_byte,
  // voice events
  output logic             evt_valid,
  input  wire logic        evt_stall,
  output logic             key_on,
  output logic [1:0]       chip_index,
  output logic [2:0]       slot_index,
  output logic [7:0]       note_number
);

  localparam logic REG_DRUM = 1'b0;  // register index, word address

  logic [DRUM_W-1:0] drum_channel;
  logic              rx_accept;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;

  // drum channel register; only word 0 exists
  always_ff @(posedge clk) begin
    if (rst) begin
      drum_channel <= DRUM_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DRUM)) begin
      drum_channel <= pwdata[DRUM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DRUM) prdata = {{(32-DRUM_W){1'b0}}, drum_channel};
  end

  mnva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_accept (rx_accept),
    .cmd       (cmd),
    .sts       (sts)
  );

  mnva_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_accept    (rx_accept),
    .rx_byte      (rx_byte),
    .drum_channel (drum_channel),
    .cmd          (cmd),
    .sts          (sts),
    .evt_stall    (evt_stall),
    .evt_valid    (evt_valid),
    .key_on       (key_on),
    .chip_index   (chip_index),
    .slot_index   (slot_index),
    .note_number  (note_number)
  );

endmodule
`default_nettype wire

/* sv/mnva_ctrl.sv */
// Controller: waits for a completed note message, then steps the voice scan.
`default_nettype none
module mnva_ctrl
  import mnva_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic rx_valid,
  output logic      rx_stall,
  output logic      rx_accept,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t state;

  assign rx_stall  = (state != ST_IDLE);
  assign rx_accept = rx_valid && (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.scan_clear = rx_accept && sts.note_ready;
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.take_hit = sts.out_free;
        end else begin
          cmd.scan_adv = !sts.last;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (rx_accept && sts.note_ready) state <= ST_SCAN;
        end
        ST_SCAN: begin
          // hit waiting on a full output register holds the scan
          if (sts.hit) begin
            if (sts.out_free) state <= ST_IDLE;
          end else if (sts.last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/mnva_dp.sv */
// Datapath: MIDI parser registers, voice table, scan counters and output register.
`default_nettype none
module mnva_dp
  import mnva_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rx_accept,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [DRUM_W-1:0] drum_channel,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              evt_stall,
  output logic                   evt_valid,
  output logic                   key_on,
  output logic [1:0]             chip_index,
  output logic [2:0]             slot_index,
  output logic [7:0]             note_number
);

  typedef enum logic [1:0] {PH_STATUS, PH_DATA1, PH_DATA2} phase_t;
  typedef enum logic [1:0] {K_NOTE_OFF, K_NOTE_ON, K_CTRL, K_PROG} kind_t;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;

  localparam logic [VIDX_W-1:0] VLAST = VIDX_W'(VOICE_TOTAL - 1);
  localparam logic [SLOT_W-1:0] SLAST = SLOT_W'(VOICES_PER_CHIP - 1);

  phase_t            phase;
  kind_t             kind;
  logic [3:0]        channel;
  logic [7:0]        first;

  logic [VOICE_TOTAL-1:0] busy;
  logic [7:0]             vnote [VOICE_TOTAL];

  logic [VIDX_W-1:0] vidx;
  logic [CHIP_W-1:0] chip;
  logic [SLOT_W-1:0] slot;

  logic              is_on;
  logic [CHIP_W+1:0] chip_ext;
  logic [SLOT_W+2:0] slot_ext;

  assign is_on = (kind == K_NOTE_ON);

  always_comb begin
    sts.note_ready = (phase == PH_DATA2)
                     && ((kind == K_NOTE_OFF) || (kind == K_NOTE_ON))
                     && (channel != drum_channel);
    sts.hit      = is_on ? !busy[vidx] : (busy[vidx] && (vnote[vidx] == first));
    sts.last     = (vidx == VLAST);
    sts.out_free = !evt_valid || !evt_stall;
  end

  // indices wider than the field are masked
  assign chip_ext = {2'b00, chip};
  assign slot_ext = {3'b000, slot};

  // parser
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_STATUS;
      kind    <= K_NOTE_OFF;
      channel <= '0;
      first   <= '0;
    end else if (rx_accept) begin
      unique case (phase)
        PH_DATA1: begin
          first <= rx_byte;
          phase <= (kind == K_PROG) ? PH_STATUS : PH_DATA2;
        end
        PH_DATA2: begin
          phase <= PH_STATUS;
        end
        default: begin
          channel <= rx_byte[3:0];
          phase   <= PH_STATUS;
          case (rx_byte[7:4])
            ST_NOTE_OFF: begin kind <= K_NOTE_OFF; phase <= PH_DATA1; end
            ST_NOTE_ON:  begin kind <= K_NOTE_ON;  phase <= PH_DATA1; end
            ST_CTRL:     begin kind <= K_CTRL;     phase <= PH_DATA1; end
            ST_PROG:     begin kind <= K_PROG;     phase <= PH_DATA1; end
            default: ;
          endcase
        end
      endcase
    end
  end

  // scan counters, chip and slot tracked alongside the voice number
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      vidx <= '0;
      chip <= '0;
      slot <= '0;
    end else if (cmd.scan_adv) begin
      vidx <= vidx + 1'b1;
      if (slot == SLAST) begin
        slot <= '0;
        chip <= chip + 1'b1;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  // voice table
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (cmd.take_hit) begin
      busy[vidx] <= is_on;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit && is_on) vnote[vidx] <= first;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (cmd.take_hit) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      key_on      <= is_on;
      chip_index  <= chip_ext[1:0];
      slot_index  <= slot_ext[2:0];
      note_number <= first;
    end
  end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for midi_note_voice_allocator: byte stream in, voice events out.
module tb_top;
  import mnva_pkg::*;

  // MIDI status nibbles
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY_PRESS = 4'hA;
  localparam logic [3:0] ST_CTRL       = 4'hB;
  localparam logic [3:0] ST_PROG       = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_PITCH_BEND = 4'hE;
  localparam logic [3:0] ST_SYSTEM     = 4'hF;

  // config register byte address
  localparam logic [2:0] REG_DRUM_CH = 3'd0;

  localparam int PHASE_ITEMS    = 125;
  // a finishing byte can scan the whole voice table before anything shows up
  localparam int SETTLE_CYCLES  = 2 * VOICE_TOTAL + 8;
  localparam int HOLD_AFTER     = 70;    // events seen before the long receiver hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles, well above the hold-off

  typedef enum logic [1:0] {PH_STATUS, PH_DATA1, PH_DATA2} parse_phase_t;
  typedef enum logic [1:0] {KIND_NOTE_OFF, KIND_NOTE_ON, KIND_CTRL, KIND_PROG} msg_kind_t;

  typedef struct {
    logic       key_on;
    logic [1:0] chip;
    logic [2:0] slot;
    logic [7:0] note;
  } voice_event_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports (every input known from time zero)
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = '0;
  logic        evt_valid;
  logic        evt_stall = 1'b0;
  logic        key_on;
  logic [1:0]  chip_index;
  logic [2:0]  slot_index;
  logic [7:0]  note_number;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  midi_note_voice_allocator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .evt_valid(evt_valid), .evt_stall(evt_stall),
    .key_on(key_on), .chip_index(chip_index), .slot_index(slot_index),
    .note_number(note_number)
  );

  // ---------------------------------------------------------------------------
  // Voice allocation predictor: its own copy of the parser and the voice table
  // ---------------------------------------------------------------------------
  logic [3:0]   drum_ch = DRUM_RESET;
  parse_phase_t parse_phase = PH_STATUS;
  msg_kind_t    msg_kind = KIND_NOTE_OFF;
  logic [3:0]   msg_chan = '0;
  logic [7:0]   held_note = '0;
  bit           voice_busy [VOICE_TOTAL];
  bit [7:0]     voice_note [VOICE_TOTAL];

  voice_event_t expected_events [$];

  // Called once per accepted rx transaction; queues the key event it causes, if any.
  function automatic void predict_voice_event(logic [7:0] b);
    int           hit;
    voice_event_t ev;
    hit = -1;
    case (parse_phase)
      PH_DATA1: begin
        held_note   = b;
        parse_phase = (msg_kind == KIND_PROG) ? PH_STATUS : PH_DATA2;
      end
      PH_DATA2: begin
        // second data byte (velocity) is ignored; it only completes the message
        parse_phase = PH_STATUS;
        if ((msg_kind == KIND_NOTE_ON || msg_kind == KIND_NOTE_OFF) && msg_chan != drum_ch) begin
          // first free voice for key-on, first busy voice with same note for key-off
          for (int v = 0; v < VOICE_TOTAL; v++)
            if (hit < 0 && (msg_kind == KIND_NOTE_ON ? !voice_busy[v] :
                            (voice_busy[v] && voice_note[v] == held_note)))
              hit = v;
          if (hit >= 0) begin
            voice_busy[hit] = (msg_kind == KIND_NOTE_ON);
            voice_note[hit] = held_note;
            ev.key_on = (msg_kind == KIND_NOTE_ON);
            ev.chip   = 2'(hit / VOICES_PER_CHIP);
            ev.slot   = 3'(hit % VOICES_PER_CHIP);
            ev.note   = held_note;
            expected_events.insert(expected_events.size(), ev);
          end
        end
      end
      default: begin
        // any byte here is a status byte, top bit or not
        parse_phase = PH_STATUS;
        msg_chan    = b[3:0];
        case (b[7:4])
          ST_NOTE_OFF: begin msg_kind = KIND_NOTE_OFF; parse_phase = PH_DATA1; end
          ST_NOTE_ON:  begin msg_kind = KIND_NOTE_ON;  parse_phase = PH_DATA1; end
          ST_CTRL:     begin msg_kind = KIND_CTRL;     parse_phase = PH_DATA1; end
          ST_PROG:     begin msg_kind = KIND_PROG;     parse_phase = PH_DATA1; end
          default: ;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  logic [7:0] midi_bytes [$];      // bytes waiting for the driver
  logic [7:0] sounding_notes [$];  // notes the generator believes are held

  function automatic void queue_message(logic [3:0] st, logic [3:0] ch,
                                        logic [7:0] d1, logic [7:0] d2);
    midi_bytes.insert(midi_bytes.size(), {st, ch});
    midi_bytes.insert(midi_bytes.size(), d1);
    midi_bytes.insert(midi_bytes.size(), d2);
  endfunction

  // The current drum channel now and then, otherwise any channel.
  function automatic logic [3:0] pick_channel();
    return ($urandom_range(0, 6) == 0) ? drum_ch : 4'($urandom_range(0, 15));
  endfunction

  // Queues one random message; returns how many bytes count toward the phase total.
  function automatic int queue_random_message();
    int         pick;
    int         idx;
    logic [3:0] ch;
    logic [7:0] note;
    pick = $urandom_range(0, 99);
    ch   = pick_channel();
    if (pick < 40) begin
      // note-on, sometimes a duplicate of a held note, sometimes a note byte >= 0x80
      if (sounding_notes.size() > 0 && $urandom_range(0, 6) == 0)
        note = sounding_notes[$urandom_range(0, sounding_notes.size() - 1)];
      else if ($urandom_range(0, 9) == 0)
        note = 8'($urandom_range(128, 255));
      else
        note = 8'($urandom_range(0, 127));
      if (sounding_notes.size() < 32)
        sounding_notes.insert(sounding_notes.size(), note);
      queue_message(ST_NOTE_ON, ch, note, 8'($urandom()));
      return 3;
    end
    if (pick < 75) begin
      // note-off, mostly for a note that should be sounding
      if (sounding_notes.size() > 0 && $urandom_range(0, 7) != 0) begin
        idx  = $urandom_range(0, sounding_notes.size() - 1);
        note = sounding_notes[idx];
        sounding_notes.delete(idx);
      end else begin
        note = 8'($urandom());
      end
      queue_message(ST_NOTE_OFF, ch, note, 8'($urandom()));
      return 3;
    end
    if (pick < 82) begin
      queue_message(ST_CTRL, ch, 8'($urandom()), 8'($urandom()));
      return 3;
    end
    if (pick < 87) begin
      midi_bytes.insert(midi_bytes.size(), {ST_PROG, ch});
      midi_bytes.insert(midi_bytes.size(), 8'($urandom()));
      return 2;
    end
    if (pick < 94) begin
      // a first byte the parser drops on its own
      case ($urandom_range(0, 4))
        0:       note = {1'b0, 7'($urandom())};
        1:       note = {ST_POLY_PRESS, 4'($urandom())};
        2:       note = {ST_CHAN_PRESS, 4'($urandom())};
        3:       note = {ST_PITCH_BEND, 4'($urandom())};
        default: note = {ST_SYSTEM, 4'($urandom())};
      endcase
      midi_bytes.insert(midi_bytes.size(), note);
      return 0;
    end
    // truncated note message: the next status byte gets eaten as its velocity
    midi_bytes.insert(midi_bytes.size(),
                      {($urandom_range(0, 1) ? ST_NOTE_ON : ST_NOTE_OFF), ch});
    midi_bytes.insert(midi_bytes.size(), 8'($urandom()));
    return 2;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: bursts of random length, random gaps, payload held while stalled
  // ---------------------------------------------------------------------------
  logic rx_taken = 1'b0;  // set by the monitor at the rising edge
  int   burst_left = 1;
  int   gap_left = 0;

  always @(negedge clk) begin : byte_driver
    logic       offer;
    logic [7:0] next_byte;
    offer     = rx_valid;
    next_byte = rx_byte;
    if (!rx_valid || rx_taken) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (!rst && midi_bytes.size() > 0) begin
        next_byte = midi_bytes.pop_front();
        offer     = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // new burst; about a third of them run straight on with no gap
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    rx_valid <= offer;
    rx_byte  <= next_byte;
  end

  // ---------------------------------------------------------------------------
  // Event receiver: stall pattern changes mode now and then; one long hold-off
  // lets the output back up so that the block stalls its byte input
  // ---------------------------------------------------------------------------
  int events_seen = 0;
  int hold_left = 0;
  bit held_off = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(negedge clk) begin : event_receiver
    logic stall_next;
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      if (!held_off && events_seen >= HOLD_AFTER) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       stall_next = 1'b0;
        1:       stall_next = ($urandom_range(0, 3) == 0);
        2:       stall_next = ($urandom_range(0, 3) != 0);
        default: stall_next = ~evt_stall;
      endcase
    end
    evt_stall <= stall_next;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every byte transaction, checks every event transaction
  // against the oldest expectation, and runs the watchdog
  // ---------------------------------------------------------------------------
  int failures = 0;
  int quiet_cycles = 0;

  always @(posedge clk) begin : monitor
    logic         evt_taken;
    voice_event_t want;
    rx_taken  = !rst && rx_valid && !rx_stall;
    evt_taken = !rst && evt_valid && !evt_stall;
    // predict first so an event can never overtake its own expectation
    if (rx_taken)
      predict_voice_event(rx_byte);
    if (evt_taken) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        $error("unexpected event: key_on %0d chip %0d slot %0d note %0h",
               key_on, chip_index, slot_index, note_number);
        failures++;
      end else begin
        want = expected_events.pop_front();
        if (key_on !== want.key_on) begin
          $error("key_on: expected %0d, got %0d", want.key_on, key_on);
          failures++;
        end
        if (chip_index !== want.chip) begin
          $error("chip_index: expected %0d, got %0d", want.chip, chip_index);
          failures++;
        end
        if (slot_index !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, slot_index);
          failures++;
        end
        if (note_number !== want.note) begin
          $error("note_number: expected %0h, got %0h", want.note, note_number);
          failures++;
        end
      end
    end
    if (rx_taken || evt_taken || (psel && penable && pwrite && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  // Wait until every byte is in and every event out, then let a full scan go by
  // in case the last byte finished a note that found no voice.
  task automatic drain();
    while (midi_bytes.size() != 0 || rx_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, register taken while pready is high.
  // Upper data bits are junk; only the low nibble should land.
  task automatic write_drum_channel(input logic [3:0] ch);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DRUM_CH;
    pwdata  <= {28'($urandom()), ch};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    drum_ch = ch;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         count;
    logic [3:0] drum_plan [4];
    logic [7:0] fill_notes [$];

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: reset drum channel (9) still in force
    queue_message(ST_NOTE_ON, 4'h0, 8'h00, 8'h00);   // zero velocity still keys on
    queue_message(ST_NOTE_ON, 4'hF, 8'h7F, 8'h7F);
    queue_message(ST_NOTE_ON, 4'h1, 8'hFF, 8'h80);   // data bytes with top bit set
    queue_message(ST_NOTE_ON, 4'h9, 8'h40, 8'h40);   // drum channel, ignored
    queue_message(ST_NOTE_OFF, 4'h2, 8'h7F, 8'h00);  // frees the voice holding 0x7F
    queue_message(ST_NOTE_OFF, 4'h0, 8'h55, 8'h00);  // nothing holds it
    queue_message(ST_CTRL, 4'h3, 8'h07, 8'h64);
    midi_bytes.insert(midi_bytes.size(), {ST_PROG, 4'h5});
    midi_bytes.insert(midi_bytes.size(), 8'h10);
    midi_bytes.insert(midi_bytes.size(), 8'h7F);                  // stray data byte as status
    midi_bytes.insert(midi_bytes.size(), {ST_POLY_PRESS, 4'h0});
    midi_bytes.insert(midi_bytes.size(), {ST_CHAN_PRESS, 4'hF});
    midi_bytes.insert(midi_bytes.size(), {ST_SYSTEM, 4'h8});
    drain();

    // Fill every voice, with a duplicate note and notes that find no voice,
    // then release them all
    write_drum_channel(4'd0);
    fill_notes = {8'd60, 8'd60};
    repeat (18) fill_notes.insert(fill_notes.size(), 8'($urandom_range(0, 127)));
    foreach (fill_notes[i])
      queue_message(ST_NOTE_ON, 4'($urandom_range(1, 15)), fill_notes[i], 8'($urandom()));
    queue_message(ST_NOTE_ON, 4'd0, 8'd61, 8'd100);
    foreach (fill_notes[i])
      queue_message(ST_NOTE_OFF, 4'($urandom_range(1, 15)), fill_notes[i], 8'h00);
    drain();

    // Random phases, one drum channel setting each, extremes included
    drum_plan = '{4'd15, 4'($urandom_range(1, 14)), 4'd0, 4'd9};
    foreach (drum_plan[p]) begin
      write_drum_channel(drum_plan[p]);
      sounding_notes.delete();
      count = 0;
      while (count < PHASE_ITEMS)
        count += queue_random_message();
      drain();
    end

    if (failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
